// File: rtl/srb_pkg.sv
`timescale 1ns / 1ps

package srb_pkg;

   // action codes
   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_STOP   = 3'd2;
   localparam logic [2:0] ACT_PAUSE  = 3'd3;
   localparam logic [2:0] ACT_RESUME = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_DEF_MINUTES = 3'd0;
   localparam logic [2:0] CSR_DEF_BRIGHT  = 3'd1;
   localparam logic [2:0] CSR_DEF_RED     = 3'd2;
   localparam logic [2:0] CSR_DEF_GREEN   = 3'd3;
   localparam logic [2:0] CSR_DEF_BLUE    = 3'd4;

   localparam int ACT_W    = 3;
   localparam int IDX_W    = 3;
   localparam int MIN_W    = 8;
   localparam int PCT_W    = 7;
   localparam int COL_W    = 8;
   localparam int LEN_W    = 24;
   localparam int NUM_W    = 32;
   localparam int DEN_W    = LEN_W + 1;
   localparam int QUO_W    = 7;
   localparam int CNT_W    = 3;
   localparam int PROD_W   = PCT_W + LEN_W;

   localparam int TIME_BITS_DEF   = 32;
   localparam int THROTTLE_MS_DEF = 100;

   localparam logic [LEN_W-1:0] MS_PER_MIN = LEN_W'(60000);
   localparam logic [LEN_W-1:0] MIN_LEN_MS = LEN_W'(1000);
   localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);

   typedef struct packed {
      logic [MIN_W-1:0] minutes;
      logic [PCT_W-1:0] bright;
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
   } srb_defaults_type;

   typedef struct packed {
      logic             go;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } srb_div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } srb_div_rsp_type;

endpackage

// File: rtl/sunrise_brightness_ramp.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  action, duration, brightness, colour
// rsp_      out        rsp_valid/rsp_stall  power, mode, brightness, progress, colour, flags
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A command passes DECODE and RESPOND after accept, a tick without an update also CHECK, a completing
// tick also COMPARE; an update runs one or two passes of the shared 7-step divider (one if the target is 0).
// One transaction is worked on at a time; req_stall is high until the result is registered.
// A waiting result is held while rsp_stall is high; the next transaction may be accepted.
// Reset is synchronous, active high, clears the ramp state and restores the defaults.

module sunrise_brightness_ramp
   import srb_pkg::*;
#(
   parameter int TIME_BITS   = TIME_BITS_DEF,
   parameter int THROTTLE_MS = THROTTLE_MS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ACT_W-1:0] req_action,
   input  logic [MIN_W-1:0] req_duration_minutes,
   input  logic [PCT_W-1:0] req_final_brightness,
   input  logic [COL_W-1:0] req_red_in,
   input  logic [COL_W-1:0] req_green_in,
   input  logic [COL_W-1:0] req_blue_in,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_power_on,
   output logic             rsp_mode,
   output logic [PCT_W-1:0] rsp_brightness,
   output logic [PCT_W-1:0] rsp_progress_pct,
   output logic [COL_W-1:0] rsp_red_out,
   output logic [COL_W-1:0] rsp_green_out,
   output logic [COL_W-1:0] rsp_blue_out,
   output logic             rsp_is_paused,
   output logic             rsp_finished,
   output logic             rsp_changed,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [COL_W-1:0] csr_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_CHECK   = 3'd2;
   localparam logic [2:0] ST_COMPARE = 3'd3;
   localparam logic [2:0] ST_DIV_PCT = 3'd4;
   localparam logic [2:0] ST_DIV_LVL = 3'd5;
   localparam logic [2:0] ST_APPLY   = 3'd6;
   localparam logic [2:0] ST_RESPOND = 3'd7;

   srb_defaults_type defaults;
   srb_div_req_type  div_req;
   srb_div_rsp_type  div_rsp;

   logic [2:0]           state_ff, state_in;
   logic [ACT_W-1:0]     act_ff, act_in;
   logic [MIN_W-1:0]     mins_ff, mins_in;
   logic [PCT_W-1:0]     bri_ff, bri_in;
   logic [COL_W-1:0]     r_ff, r_in, g_ff, g_in, b_ff, b_in;

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] pause_el_ff, pause_el_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 running_ff, running_in;
   logic                 held_ff, held_in;
   logic [PCT_W-1:0]     target_ff, target_in;
   logic [COL_W-1:0]     tr_ff, tr_in, tg_ff, tg_in, tb_ff, tb_in;
   logic [PCT_W-1:0]     level_ff, level_in;
   logic [PCT_W-1:0]     percent_ff, percent_in;
   logic                 lamp_ff, lamp_in;
   logic                 ramp_ff, ramp_in;
   logic                 fin_ff, fin_in;
   logic                 chg_ff, chg_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic [PCT_W-1:0]     lvl_ff, lvl_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_flags_ff, rsp_flags_in;
   logic                 rsp_lamp_ff, rsp_lamp_in, rsp_ramp_ff, rsp_ramp_in;
   logic                 rsp_held_ff, rsp_held_in;
   logic [PCT_W-1:0]     rsp_lvl_ff, rsp_lvl_in, rsp_pct_ff, rsp_pct_in;
   logic [COL_W-1:0]     rsp_r_ff, rsp_r_in, rsp_g_ff, rsp_g_in, rsp_b_ff, rsp_b_in;

   logic                 req_take;
   logic [MIN_W-1:0]     mins_eff;
   logic                 col_zero;
   logic [TIME_BITS-1:0] since_last;
   logic [LEN_W-1:0]     len_eff;
   logic [LEN_W-1:0]     e24;
   logic [NUM_W-1:0]     dividend_pct;
   logic [NUM_W-1:0]     dividend_lvl;
   logic [PCT_W:0]       lvl_sum;

   srb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .defaults  (defaults)
   );

   srb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      mins_eff     = (mins_ff != '0) ? mins_ff : defaults.minutes;
      col_zero     = (r_ff == '0) && (g_ff == '0) && (b_ff == '0);
      since_last   = now_ff - last_ff;
      len_eff      = (len_ff != '0) ? len_ff : MIN_LEN_MS;
      e24          = elapsed_ff[LEN_W-1:0];
      // 200*e + d, and 2*(t-1)*e + d
      dividend_pct = (NUM_W'(e24) << 7) + (NUM_W'(e24) << 6) + (NUM_W'(e24) << 3)
                     + NUM_W'(len_eff);
      dividend_lvl = (NUM_W'(prod_ff) << 1) + NUM_W'(len_eff);
      lvl_sum      = {1'b0, div_rsp.quotient} + 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      mins_in     = mins_ff;
      bri_in      = bri_ff;
      r_in        = r_ff;
      g_in        = g_ff;
      b_in        = b_ff;
      now_in      = now_ff;
      start_in    = start_ff;
      pause_el_in = pause_el_ff;
      last_in     = last_ff;
      elapsed_in  = elapsed_ff;
      len_in      = len_ff;
      running_in  = running_ff;
      held_in     = held_ff;
      target_in   = target_ff;
      tr_in       = tr_ff;
      tg_in       = tg_ff;
      tb_in       = tb_ff;
      level_in    = level_ff;
      percent_in  = percent_ff;
      lamp_in     = lamp_ff;
      ramp_in     = ramp_ff;
      fin_in      = fin_ff;
      chg_in      = chg_ff;
      pct_in      = pct_ff;
      lvl_in      = lvl_ff;
      prod_in     = prod_ff;
      div_req.go       = 1'b0;
      div_req.dividend = dividend_pct;
      div_req.divisor  = {len_eff, 1'b0};

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_flags_in = rsp_flags_ff;
      rsp_lamp_in  = rsp_lamp_ff;
      rsp_ramp_in  = rsp_ramp_ff;
      rsp_held_in  = rsp_held_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_g_in     = rsp_g_ff;
      rsp_b_in     = rsp_b_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               act_in   = req_action;
               mins_in  = req_duration_minutes;
               bri_in   = req_final_brightness;
               r_in     = req_red_in;
               g_in     = req_green_in;
               b_in     = req_blue_in;
               fin_in   = 1'b0;
               chg_in   = 1'b0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESPOND;
            case (act_ff)
               ACT_TICK: begin
                  now_in   = now_ff + 1'b1;
                  state_in = ST_CHECK;
               end
               ACT_START: begin
                  running_in  = 1'b1;
                  held_in     = 1'b0;
                  start_in    = now_ff;
                  pause_el_in = '0;
                  target_in   = (bri_ff != '0) ? bri_ff : defaults.bright;
                  tr_in       = col_zero ? defaults.red   : r_ff;
                  tg_in       = col_zero ? defaults.green : g_ff;
                  tb_in       = col_zero ? defaults.blue  : b_ff;
                  len_in      = (mins_eff == '0) ? MIN_LEN_MS
                                : LEN_W'(LEN_W'(mins_eff) * MS_PER_MIN);
                  ramp_in     = 1'b1;
                  lamp_in     = 1'b1;
                  level_in    = PCT_W'(1);
                  percent_in  = '0;
                  chg_in      = 1'b1;
               end
               ACT_STOP: begin
                  if (running_ff) begin
                     running_in = 1'b0;
                     held_in    = 1'b0;
                     ramp_in    = 1'b0;
                     chg_in     = 1'b1;
                  end
               end
               ACT_PAUSE: begin
                  if (running_ff && !held_ff) begin
                     held_in     = 1'b1;
                     pause_el_in = now_ff - start_ff;
                     chg_in      = 1'b1;
                  end
               end
               ACT_RESUME: begin
                  if (running_ff && held_ff) begin
                     held_in     = 1'b0;
                     start_in    = now_ff - pause_el_ff;
                     pause_el_in = '0;
                     chg_in      = 1'b1;
                  end
               end
               default: state_in = ST_RESPOND;
            endcase
         end
         ST_CHECK: begin
            if (!running_ff || held_ff ||
                since_last < TIME_BITS'(THROTTLE_MS)) begin
               state_in = ST_RESPOND;
            end else begin
               last_in    = now_ff;
               elapsed_in = now_ff - start_ff;
               state_in   = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (elapsed_ff >= TIME_BITS'(len_eff)) begin
               level_in   = target_ff;
               percent_in = PCT_FULL;
               lamp_in    = 1'b1;
               running_in = 1'b0;
               held_in    = 1'b0;
               ramp_in    = 1'b0;
               fin_in     = 1'b1;
               chg_in     = 1'b1;
               state_in   = ST_RESPOND;
            end else begin
               prod_in    = PROD_W'((target_ff - 1'b1) * e24);
               div_req.go = 1'b1;
               state_in   = ST_DIV_PCT;
            end
         end
         ST_DIV_PCT: begin
            if (div_rsp.done) begin
               pct_in = div_rsp.quotient;
               if (target_ff == '0) begin
                  lvl_in   = PCT_W'(1);
                  state_in = ST_APPLY;
               end else begin
                  div_req.go       = 1'b1;
                  div_req.dividend = dividend_lvl;
                  state_in         = ST_DIV_LVL;
               end
            end
         end
         ST_DIV_LVL: begin
            if (div_rsp.done) begin
               lvl_in   = (lvl_sum > (PCT_W + 1)'(100)) ? PCT_FULL : lvl_sum[PCT_W-1:0];
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            chg_in     = (pct_ff != percent_ff) || (lvl_ff != level_ff);
            percent_in = pct_ff;
            level_in   = lvl_ff;
            lamp_in    = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_flags_in = {fin_ff, chg_ff};
               rsp_lamp_in  = lamp_ff;
               rsp_ramp_in  = ramp_ff;
               rsp_held_in  = held_ff;
               rsp_lvl_in   = level_ff;
               rsp_pct_in   = percent_ff;
               rsp_r_in     = tr_ff;
               rsp_g_in     = tg_ff;
               rsp_b_in     = tb_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         start_ff     <= '0;
         pause_el_ff  <= '0;
         last_ff      <= '0;
         len_ff       <= '0;
         running_ff   <= 1'b0;
         held_ff      <= 1'b0;
         target_ff    <= PCT_FULL;
         tr_ff        <= '1;
         tg_ff        <= '1;
         tb_ff        <= '1;
         level_ff     <= '0;
         percent_ff   <= '0;
         lamp_ff      <= 1'b0;
         ramp_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         chg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         start_ff     <= start_in;
         pause_el_ff  <= pause_el_in;
         last_ff      <= last_in;
         len_ff       <= len_in;
         running_ff   <= running_in;
         held_ff      <= held_in;
         target_ff    <= target_in;
         tr_ff        <= tr_in;
         tg_ff        <= tg_in;
         tb_ff        <= tb_in;
         level_ff     <= level_in;
         percent_ff   <= percent_in;
         lamp_ff      <= lamp_in;
         ramp_ff      <= ramp_in;
         fin_ff       <= fin_in;
         chg_ff       <= chg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      mins_ff      <= mins_in;
      bri_ff       <= bri_in;
      r_ff         <= r_in;
      g_ff         <= g_in;
      b_ff         <= b_in;
      elapsed_ff   <= elapsed_in;
      pct_ff       <= pct_in;
      lvl_ff       <= lvl_in;
      prod_ff      <= prod_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_lamp_ff  <= rsp_lamp_in;
      rsp_ramp_ff  <= rsp_ramp_in;
      rsp_held_ff  <= rsp_held_in;
      rsp_lvl_ff   <= rsp_lvl_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_r_ff     <= rsp_r_in;
      rsp_g_ff     <= rsp_g_in;
      rsp_b_ff     <= rsp_b_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_on     = rsp_lamp_ff;
   assign rsp_mode         = rsp_ramp_ff;
   assign rsp_brightness   = rsp_lvl_ff;
   assign rsp_progress_pct = rsp_pct_ff;
   assign rsp_red_out      = rsp_r_ff;
   assign rsp_green_out    = rsp_g_ff;
   assign rsp_blue_out     = rsp_b_ff;
   assign rsp_is_paused    = rsp_held_ff;
   assign rsp_finished     = rsp_flags_ff[1];
   assign rsp_changed      = rsp_flags_ff[0];

endmodule

// File: rtl/srb_csr.sv
`timescale 1ns / 1ps

module srb_csr
   import srb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [COL_W-1:0]       csr_data,
   output srb_defaults_type       defaults
);

   srb_defaults_type regs_ff;
   srb_defaults_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEF_MINUTES: regs_in.minutes = csr_data;
            CSR_DEF_BRIGHT:  regs_in.bright  = csr_data[PCT_W-1:0];
            CSR_DEF_RED:     regs_in.red     = csr_data;
            CSR_DEF_GREEN:   regs_in.green   = csr_data;
            CSR_DEF_BLUE:    regs_in.blue    = csr_data;
            default:         regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.minutes <= MIN_W'(30);
         regs_ff.bright  <= PCT_W'(100);
         regs_ff.red     <= '1;
         regs_ff.green   <= '1;
         regs_ff.blue    <= '1;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign defaults = regs_ff;

endmodule

// File: rtl/srb_div.sv
`timescale 1ns / 1ps

module srb_div
   import srb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  srb_div_req_type req,
   output srb_div_rsp_type rsp
);

   // restoring divider, one quotient bit per cycle, msb first
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] shifted;
   logic [NUM_W:0]   trial;

   always_comb begin
      shifted = NUM_W'(den_ff) << cnt_ff;
      trial   = {1'b0, rem_ff} - {1'b0, shifted};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.go) begin
         rem_in  = req.dividend;
         den_in  = req.divisor;
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[NUM_W]) begin
            rem_in         = trial[NUM_W-1:0];
            quo_in[cnt_ff] = 1'b1;
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
